// ===== rtl/core/fcpg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Filled circle point generator package
// Shared widths, command codes, decision error constants and the point
// snapshot that travels from the circle stepper to the point emitter.
// ----------------------------------------------------------------------------
package fcpg_pkg;

	localparam int PIX_W   = 13;  // Point coordinate width, two's complement.
	localparam int RAD_W   = 10;  // Radius width.
	localparam int OFS_W   = 11;  // Column and span offset width.
	localparam int ROW_W   = 12;  // Row offset width, signed (may reach -1).
	localparam int CMP_W   = ROW_W + 1;
	localparam int ERR_W   = 16;  // Decision error width, signed.
	localparam int COLOR_W = 32;

	localparam int POINTS = 8;
	localparam int IDX_W  = $clog2(POINTS);
	localparam logic [IDX_W-1:0] LAST_POINT = IDX_W'(POINTS - 1);

	localparam logic [ERR_W-1:0] ERR_INIT     = ERR_W'(3);
	localparam logic [ERR_W-1:0] ERR_STEP_IN  = ERR_W'(6);
	localparam logic [ERR_W-1:0] ERR_STEP_OUT = ERR_W'(10);

	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_NEXT  = 1'b1
	} cmd_t;

	// Everything needed to produce the eight points of one next command.
	typedef struct packed {
		logic [PIX_W-1:0]   cx;
		logic [PIX_W-1:0]   cy;
		logic [OFS_W-1:0]   col;
		logic [OFS_W-1:0]   span;
		logic               fin;
		logic [COLOR_W-1:0] color;
	} snap_t;

endpackage
`default_nettype wire

// ===== rtl/core/fcpg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Filled circle point generator channels
// Command channel and pixel channel, each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fcpg_cmd_if #(
	parameter int COORD_BITS = 11
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;
	logic [9:0]            radius;
	logic [31:0]           color;

	modport source (output valid, command, center_x, center_y, radius, color,
		input ready);
	modport sink (input valid, command, center_x, center_y, radius, color,
		output ready);
endinterface

interface fcpg_pix_if;
	logic               valid;
	logic               ready;
	logic signed [12:0] pixel_x;
	logic signed [12:0] pixel_y;
	logic [31:0]        pixel_color;
	logic               last;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fcpg_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Filled circle stepper
// Holds circle state; each next command widens the span or steps the decision.
// ----------------------------------------------------------------------------
module fcpg_step
	import fcpg_pkg::*;
#(
	parameter int COORD_BITS = 11
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic                  command,
	input  wire logic [COORD_BITS-1:0] center_x,
	input  wire logic [COORD_BITS-1:0] center_y,
	input  wire logic [RAD_W-1:0]      radius,
	input  wire logic [COLOR_W-1:0]    color,
	output logic                       emit,
	output snap_t                      snap
);

	logic                  busy_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [OFS_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [OFS_W-1:0]      span_q;
	logic [ERR_W-1:0]      err_q;
	logic [COLOR_W-1:0]    color_q;

	logic [OFS_W-1:0] span_inc;
	logic [OFS_W-1:0] col_inc;
	logic             past_row;
	logic             err_neg;
	logic [ERR_W-1:0] row_ext;
	logic [ERR_W-1:0] err_in;
	logic [ERR_W-1:0] err_out;
	logic [ROW_W-1:0] row_after;
	logic             fin;

	assign span_inc = span_q + OFS_W'(1);
	assign col_inc  = col_q + OFS_W'(1);
	assign err_neg  = err_q[ERR_W-1];
	assign row_ext  = ERR_W'($signed(row_q));

	// The span passes the row once span + 1 exceeds it; the row is signed.
	assign past_row = $signed(CMP_W'(span_inc)) > $signed({row_q[ROW_W-1], row_q});

	assign err_in    = err_q + (ERR_W'(col_q) << 2) + ERR_STEP_IN;
	assign err_out   = err_q + ((ERR_W'(col_q) - row_ext) << 2) + ERR_STEP_OUT;
	assign row_after = err_neg ? row_q : row_q - ROW_W'(1);
	assign fin = past_row &&
		($signed(CMP_W'(col_inc)) > $signed({row_after[ROW_W-1], row_after}));

	assign emit = accept && (command == CMD_NEXT) && busy_q;

	always_comb begin
		snap.cx    = PIX_W'(cx_q);
		snap.cy    = PIX_W'(cy_q);
		snap.col   = col_q;
		snap.span  = span_q;
		snap.fin   = fin;
		snap.color = color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cx_q    <= '0;
			cy_q    <= '0;
			col_q   <= '0;
			row_q   <= '0;
			span_q  <= '0;
			err_q   <= '0;
			color_q <= '0;
		end else if (accept && command == CMD_START) begin
			busy_q  <= 1'b1;
			cx_q    <= center_x;
			cy_q    <= center_y;
			col_q   <= '0;
			row_q   <= ROW_W'(radius);
			span_q  <= '0;
			err_q   <= ERR_INIT - ERR_W'({radius, 1'b0});
			color_q <= color;
		end else if (emit) begin
			if (past_row) begin
				err_q  <= err_neg ? err_in : err_out;
				row_q  <= row_after;
				col_q  <= col_inc;
				span_q <= col_inc;
				if (fin) begin
					busy_q <= 1'b0;
				end
			end else begin
				span_q <= span_inc;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fcpg_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Filled circle point emitter
// Walks the eight symmetric points of one snapshot into the output register.
// ----------------------------------------------------------------------------
module fcpg_emit
	import fcpg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire snap_t              snap,
	output logic                    can_take,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [PIX_W-1:0] out_x,
	output logic signed [PIX_W-1:0] out_y,
	output logic [COLOR_W-1:0]      out_color,
	output logic                    out_last
);

	logic                  active_q;
	logic [IDX_W-1:0]      idx_q;
	snap_t                 base_q;
	logic                  out_valid_q;
	logic [PIX_W-1:0]      out_x_q;
	logic [PIX_W-1:0]      out_y_q;
	logic [COLOR_W-1:0]    out_color_q;
	logic                  out_last_q;

	logic             out_load;
	logic [PIX_W-1:0] col_w;
	logic [PIX_W-1:0] span_w;
	logic [PIX_W-1:0] pt_x;
	logic [PIX_W-1:0] pt_y;

	assign out_load = active_q && (!out_valid_q || out_ready);
	assign can_take = !active_q || (idx_q == LAST_POINT && out_load);

	assign col_w  = PIX_W'(base_q.col);
	assign span_w = PIX_W'(base_q.span);

	always_comb begin
		unique case (idx_q)
			3'd0: begin pt_x = base_q.cx + col_w;  pt_y = base_q.cy + span_w; end
			3'd1: begin pt_x = base_q.cx + col_w;  pt_y = base_q.cy - span_w; end
			3'd2: begin pt_x = base_q.cx - col_w;  pt_y = base_q.cy + span_w; end
			3'd3: begin pt_x = base_q.cx - col_w;  pt_y = base_q.cy - span_w; end
			3'd4: begin pt_x = base_q.cx + span_w; pt_y = base_q.cy + col_w;  end
			3'd5: begin pt_x = base_q.cx + span_w; pt_y = base_q.cy - col_w;  end
			3'd6: begin pt_x = base_q.cx - span_w; pt_y = base_q.cy + col_w;  end
			default: begin pt_x = base_q.cx - span_w; pt_y = base_q.cy - col_w; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_color_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				idx_q    <= '0;
				base_q   <= snap;
			end else if (out_load) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q == LAST_POINT) begin
					active_q <= 1'b0;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				out_x_q     <= pt_x;
				out_y_q     <= pt_y;
				out_color_q <= base_q.color;
				out_last_q  <= base_q.fin && (idx_q == LAST_POINT);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_color = out_color_q;
	assign out_last  = out_last_q;

	// A new snapshot never overwrites one that still has points to give.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!active_q || (idx_q == LAST_POINT && out_load)))
		else $error("snapshot loaded while points remain");

	// Points other than the eighth keep the emitter active.
	a_keep_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && idx_q != LAST_POINT) |=> active_q)
		else $error("emitter went idle mid snapshot");

	// The output register only fills from an active snapshot.
	a_fill_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(active_q))
		else $error("output filled without a snapshot");

endmodule
`default_nettype wire

// ===== rtl/core/filled_circle_point_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Filled circle point generator
// Midpoint circle rasterizer that fills the circle by spans, eight points
// per next command.
// ----------------------------------------------------------------------------
// Timing: a next command's snapshot is first registered in the emitter,
// then its first point in the output register; its eight points leave
// one per cycle while pix.ready takes them. A new command is accepted
// as the eighth point leaves; start commands produce no word.
// Reset: arst_n clears the circle state, the emitter and the output valid.
module filled_circle_point_generator
	import fcpg_pkg::*;
#(
	parameter int COORD_BITS = 11
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fcpg_cmd_if.sink     cmd,
	fcpg_pix_if.source   pix
);

	// A command word is taken whenever the emitter can accept a fresh
	// snapshot: when it is idle, or in the cycle its eighth point leaves.
	// The output register decouples the pixel side, so the next command is
	// already being stepped while the final point waits to be taken.
	logic  can_take;
	logic  accept;
	logic  emit;
	snap_t snap;

	assign cmd.ready = can_take;
	assign accept    = cmd.valid && can_take;

	// The stepper holds the circle and, for each next command, hands the
	// current column, span and last flag to the emitter and, in that cycle,
	// widens the span or, past the row, steps error, row, column and span.
	fcpg_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.command  (cmd.command),
		.center_x (cmd.center_x),
		.center_y (cmd.center_y),
		.radius   (cmd.radius),
		.color    (cmd.color),
		.emit     (emit),
		.snap     (snap)
	);

	// The emitter mirrors the snapshot into its eight symmetric points and
	// registers each one on the pixel channel. Only the eighth point of the
	// final snapshot of a circle carries the last flag.
	fcpg_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.snap      (snap),
		.can_take  (can_take),
		.out_valid (pix.valid),
		.out_ready (pix.ready),
		.out_x     (pix.pixel_x),
		.out_y     (pix.pixel_y),
		.out_color (pix.pixel_color),
		.out_last  (pix.last)
	);

endmodule
`default_nettype wire
